// File: src/mbg_pkg.sv
// Shared types and constants of the maze backtracker generator.
package mbg_pkg;

    // Command codes of a request
    localparam logic [1:0] CMD_RESTART = 2'd0;
    localparam logic [1:0] CMD_STEP    = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [6:0] CFG_DIM_RESET = 7'd32;
    localparam logic [6:0] DIM_MIN       = 7'd4;

    // Directions, in scan order
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    // Cell word: walls in [3:0], visited in [4], trail in [5]
    localparam int          CELL_W      = 6;
    localparam int          BIT_VISITED = 4;
    localparam int          BIT_TRAIL   = 5;
    localparam logic [5:0]  CELL_RESET  = 6'h0F;
    localparam logic [5:0]  MARK_VISIT  = 6'h10;
    localparam logic [5:0]  MARK_TRAIL  = 6'h20;
    localparam logic [5:0]  CELL_START  = 6'h3F;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [7:0] random_value;
    } t_req;

    typedef struct packed {
        logic [5:0]  pos_x;
        logic [5:0]  pos_y;
        logic [5:0]  next_x;
        logic [5:0]  next_y;
        logic [3:0]  wall_bits;
        logic        visited_mark;
        logic        trail_mark;
        logic        generating;
        logic [12:0] stack_depth;
    } t_rsp;

    typedef struct packed {
        logic [1:0] index;
        logic [6:0] value;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ARR_RD,
        S_ARR_WR,
        S_SCAN,
        S_PICK,
        S_WR_TGT,
        S_POP,
        S_REP_RD,
        S_REP_OUT
    } t_state;

endpackage

// File: src/mbg_if.sv
// Handshake channel interfaces: request, response and configuration write.
interface mbg_req_if import mbg_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mbg_rsp_if import mbg_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mbg_cfg_if import mbg_pkg::*; ();
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/mbg_ram.sv
// Single-port RAM with registered read data.
module mbg_ram #(
    parameter int AW = 12,
    parameter int DW = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    // Write or read one word per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/mbg_pick.sv
// Neighbour picker: candidate count, random value modulo count, chosen direction.
module mbg_pick import mbg_pkg::*; (
    input  logic [3:0] i_cand,
    input  logic [7:0] i_rnd,
    output logic       o_any,
    output logic [1:0] o_dir
);

    logic [2:0] count;
    logic [3:0] digit_sum;
    logic [2:0] fold;
    logic [2:0] mod3;
    logic [1:0] idx;
    logic [2:0] seen;

    // Count the free neighbours
    always_comb begin
        count = 3'(i_cand[0]) + 3'(i_cand[1]) + 3'(i_cand[2]) + 3'(i_cand[3]);
        o_any = (count != 3'd0);
    end

    // Reduce modulo three by summing base-4 digits
    always_comb begin
        digit_sum = 4'(i_rnd[1:0]) + 4'(i_rnd[3:2]) + 4'(i_rnd[5:4]) + 4'(i_rnd[7:6]);
        fold      = 3'(digit_sum[3:2]) + 3'(digit_sum[1:0]);
        if (fold >= 3'd6) begin
            mod3 = fold - 3'd6;
        end else if (fold >= 3'd3) begin
            mod3 = fold - 3'd3;
        end else begin
            mod3 = fold;
        end
    end

    // Select the position among the candidates
    always_comb begin
        case (count)
            3'd2:    idx = {1'b0, i_rnd[0]};
            3'd3:    idx = mod3[1:0];
            3'd4:    idx = i_rnd[1:0];
            default: idx = 2'd0;
        endcase
    end

    // Walk the candidates in scan order to the selected one
    always_comb begin
        seen  = 3'd0;
        o_dir = DIR_RIGHT;
        for (int k = 0; k < 4; k++) begin
            if (i_cand[k]) begin
                if (seen == {1'b0, idx}) begin
                    o_dir = 2'(k);
                end
                seen = seen + 3'd1;
            end
        end
    end

endmodule

// File: src/maze_backtracker_generator_unit.sv
// Randomized depth-first maze generator: sequencer around a cell store and a path stack.
//
// Restart clears the cell store with one write per cycle over all
// 2**(clog2(MAX_COLUMNS)+clog2(MAX_ROWS)) locations, marks the start cell in the sweep and
// then reads it back for the response; the same sweep runs once after reset, during which
// no request is taken. A step works through the single port of the cell store in order: it
// reads and marks the arrival cell, reads the four neighbours, picks one and opens the wall
// (or starts the stack read), opens the second wall (or takes the popped target), and reads
// the reported cell; a step that ends the walk goes from the pick straight to that read. A
// read or a step after generation finished goes straight to reading the reported cell. One
// request is worked at a time; the response sits in an output register, so the next request
// is taken while it waits. Configuration writes are always taken and should be made while idle.
module maze_backtracker_generator_unit import mbg_pkg::*; #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64,
    parameter int STACK_DEPTH = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mbg_req_if.sink       i_req,
    mbg_rsp_if.source     o_rsp,
    mbg_cfg_if.sink       i_cfg
);

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int AW  = CW + RW;
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [8:0]     MAXC    = 9'(MAX_COLUMNS);
    localparam logic [8:0]     MAXR    = 9'(MAX_ROWS);
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

    t_state         r_state, n_state;
    logic [6:0]     r_cols, r_rows;
    logic [CW-1:0]  r_run_x, r_tgt_x;
    logic [RW-1:0]  r_run_y, r_tgt_y;
    logic [SPW-1:0] r_sp;
    logic           r_active;
    logic [AW-1:0]  r_clr_addr;
    logic           r_clr_mark;
    logic [7:0]     r_rnd;
    logic [2:0]     r_dir;
    logic           r_prev_ok;
    logic [3:0]     r_cand;
    logic [5:0]     r_nb_cell [4];
    logic [5:0]     r_cell;
    logic [1:0]     r_pick_dir;
    logic [5:0]     r_rep_x, r_rep_y;
    logic [AW-1:0]  r_rep_addr;
    logic           r_rep_in;
    t_rsp           r_out;
    logic           r_out_valid;

    logic [8:0]     eff_c, eff_r;
    logic [CW-1:0]  sat_x;
    logic [RW-1:0]  sat_y;
    logic           req_fire, out_free;
    logic           scan_ok;
    logic [CW-1:0]  scan_x, pick_x;
    logic [RW-1:0]  scan_y, pick_y;
    logic [1:0]     prev_dir;
    logic           pick_any;
    logic [1:0]     pick_dir;
    logic [1:0]     opp_dir;

    logic           cell_we, cell_re;
    logic [AW-1:0]  cell_addr;
    logic [5:0]     cell_wdata, cell_rdata;
    logic           stk_we, stk_re;
    logic [SAW-1:0] stk_addr;
    logic [AW-1:0]  stk_wdata, stk_rdata;

    // Neighbour in a direction, checked against the grid in use
    function automatic logic nb_ok(input logic [CW-1:0] x, input logic [RW-1:0] y,
                                   input logic [1:0] d, input logic [8:0] ec,
                                   input logic [8:0] er);
        logic [8:0] nx;
        logic [8:0] ny;
        logic       under;
        nx    = 9'(x);
        ny    = 9'(y);
        under = 1'b0;
        case (d)
            DIR_RIGHT: nx = nx + 9'd1;
            DIR_DOWN:  ny = ny + 9'd1;
            DIR_LEFT: begin
                under = (x == '0);
                nx    = nx - 9'd1;
            end
            default: begin
                under = (y == '0);
                ny    = ny - 9'd1;
            end
        endcase
        return !under && (nx < ec) && (ny < er);
    endfunction

    function automatic logic [CW-1:0] nb_x(input logic [CW-1:0] x, input logic [1:0] d);
        case (d)
            DIR_RIGHT: return x + CW'(1);
            DIR_LEFT:  return x - CW'(1);
            default:   return x;
        endcase
    endfunction

    function automatic logic [RW-1:0] nb_y(input logic [RW-1:0] y, input logic [1:0] d);
        case (d)
            DIR_DOWN: return y + RW'(1);
            DIR_UP:   return y - RW'(1);
            default:  return y;
        endcase
    endfunction

    // Clamp the grid size to the supported range
    always_comb begin
        eff_c = {2'b00, r_cols};
        if (eff_c < 9'(DIM_MIN)) eff_c = 9'(DIM_MIN);
        if (eff_c > MAXC) eff_c = MAXC;
        eff_r = {2'b00, r_rows};
        if (eff_r < 9'(DIM_MIN)) eff_r = 9'(DIM_MIN);
        if (eff_r > MAXR) eff_r = MAXR;
    end

    // Saturate the start cell into the grid
    always_comb begin
        if ({3'b000, i_req.data.cell_x} >= eff_c) begin
            sat_x = CW'(eff_c - 9'd1);
        end else begin
            sat_x = CW'(i_req.data.cell_x);
        end
        if ({3'b000, i_req.data.cell_y} >= eff_r) begin
            sat_y = RW'(eff_r - 9'd1);
        end else begin
            sat_y = RW'(i_req.data.cell_y);
        end
    end

    // Neighbour under scan and the picked neighbour
    always_comb begin
        scan_ok  = nb_ok(r_run_x, r_run_y, r_dir[1:0], eff_c, eff_r) && !r_dir[2];
        scan_x   = nb_x(r_run_x, r_dir[1:0]);
        scan_y   = nb_y(r_run_y, r_dir[1:0]);
        pick_x   = nb_x(r_run_x, pick_dir);
        pick_y   = nb_y(r_run_y, pick_dir);
        prev_dir = 2'(r_dir - 3'd1);
        opp_dir  = r_pick_dir + 2'd2;
    end

    mbg_pick u_pick (
        .i_cand (r_cand),
        .i_rnd  (r_rnd),
        .o_any  (pick_any),
        .o_dir  (pick_dir)
    );

    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == '1) n_state = r_clr_mark ? S_REP_RD : S_IDLE;
            end
            S_IDLE: begin
                if (req_fire) begin
                    case (i_req.data.command)
                        CMD_RESTART: n_state = S_CLEAR;
                        CMD_STEP:    n_state = r_active ? S_ARR_RD : S_REP_RD;
                        default:     n_state = S_REP_RD;
                    endcase
                end
            end
            S_ARR_RD: n_state = S_ARR_WR;
            S_ARR_WR: n_state = S_SCAN;
            S_SCAN: begin
                if (r_dir == 3'd4) n_state = S_PICK;
            end
            S_PICK: begin
                if (pick_any) begin
                    n_state = S_WR_TGT;
                end else if (r_sp > SPW'(1)) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_REP_RD;
                end
            end
            S_WR_TGT:  n_state = S_REP_RD;
            S_POP:     n_state = S_REP_RD;
            S_REP_RD:  n_state = S_REP_OUT;
            S_REP_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory port controls
    always_comb begin
        cell_we    = 1'b0;
        cell_re    = 1'b0;
        cell_addr  = {r_run_y, r_run_x};
        cell_wdata = r_cell;
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        stk_addr   = SAW'(r_sp);
        stk_wdata  = {r_run_y, r_run_x};
        case (r_state)
            S_CLEAR: begin
                cell_we    = 1'b1;
                cell_addr  = r_clr_addr;
                cell_wdata = (r_clr_mark && r_clr_addr == {r_run_y, r_run_x}) ?
                             CELL_START : CELL_RESET;
            end
            S_IDLE: begin
                // seed the stack with the start cell
                stk_we    = req_fire && (i_req.data.command == CMD_RESTART);
                stk_addr  = '0;
                stk_wdata = {sat_y, sat_x};
            end
            S_ARR_RD: cell_re = 1'b1;
            S_ARR_WR: begin
                cell_we    = 1'b1;
                cell_wdata = cell_rdata[BIT_VISITED] ? (cell_rdata | MARK_TRAIL) :
                             (cell_rdata | MARK_VISIT | MARK_TRAIL);
                stk_we     = !cell_rdata[BIT_VISITED] && (r_sp < SP_FULL);
            end
            S_SCAN: begin
                cell_re   = scan_ok;
                cell_addr = {scan_y, scan_x};
            end
            S_PICK: begin
                if (pick_any) begin
                    cell_we    = 1'b1;
                    cell_wdata = r_cell & ~(6'd1 << pick_dir);
                end else begin
                    stk_re   = (r_sp > SPW'(1));
                    stk_addr = SAW'(r_sp - SPW'(2));
                end
            end
            S_WR_TGT: begin
                cell_we    = 1'b1;
                cell_addr  = {r_tgt_y, r_tgt_x};
                cell_wdata = r_nb_cell[r_pick_dir] & ~(6'd1 << opp_dir);
            end
            S_REP_RD: begin
                cell_re   = r_rep_in;
                cell_addr = r_rep_addr;
            end
            default: ;
        endcase
    end

    mbg_ram #(.AW(AW), .DW(CELL_W)) u_cells (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_re    (cell_re),
        .i_addr  (cell_addr),
        .i_wdata (cell_wdata),
        .o_rdata (cell_rdata)
    );

    mbg_ram #(.AW(SAW), .DW(AW)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_re    (stk_re),
        .i_addr  (stk_addr),
        .i_wdata (stk_wdata),
        .o_rdata (stk_rdata)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CFG_DIM_RESET;
            r_rows <= CFG_DIM_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_COLUMNS: r_cols <= i_cfg.data.value;
                CFG_ROWS:    r_rows <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    // Sequencer state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_mark  <= 1'b0;
            r_sp        <= '0;
            r_active    <= 1'b0;
            r_run_x     <= '0;
            r_run_y     <= '0;
            r_tgt_x     <= '0;
            r_tgt_y     <= '0;
            r_dir       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // load a new response, or drop the one taken this cycle
            if (r_state == S_REP_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == '1) r_clr_mark <= 1'b0;
                end
                S_IDLE: begin
                    if (req_fire && i_req.data.command == CMD_RESTART) begin
                        r_run_x    <= sat_x;
                        r_run_y    <= sat_y;
                        r_tgt_x    <= sat_x;
                        r_tgt_y    <= sat_y;
                        r_sp       <= SPW'(1);
                        r_active   <= 1'b1;
                        r_clr_addr <= '0;
                        r_clr_mark <= 1'b1;
                    end else if (req_fire && i_req.data.command == CMD_STEP && r_active) begin
                        r_run_x <= r_tgt_x;
                        r_run_y <= r_tgt_y;
                    end
                end
                S_ARR_WR: begin
                    if (!cell_rdata[BIT_VISITED] && r_sp < SP_FULL) r_sp <= r_sp + SPW'(1);
                    r_dir <= '0;
                end
                S_SCAN: begin
                    r_dir <= r_dir + 3'd1;
                end
                S_PICK: begin
                    if (pick_any) begin
                        r_tgt_x <= pick_x;
                        r_tgt_y <= pick_y;
                    end else if (r_sp > SPW'(1)) begin
                        r_sp <= r_sp - SPW'(1);
                    end else begin
                        r_active <= 1'b0;
                    end
                end
                S_POP: begin
                    r_tgt_x <= stk_rdata[CW-1:0];
                    r_tgt_y <= stk_rdata[AW-1:CW];
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_rnd <= i_req.data.random_value;
                case (i_req.data.command)
                    CMD_RESTART: begin
                        r_rep_x    <= 6'(sat_x);
                        r_rep_y    <= 6'(sat_y);
                        r_rep_addr <= {sat_y, sat_x};
                        r_rep_in   <= 1'b1;
                    end
                    CMD_STEP: begin
                        r_rep_in <= 1'b1;
                        if (r_active) begin
                            r_rep_x    <= 6'(r_tgt_x);
                            r_rep_y    <= 6'(r_tgt_y);
                            r_rep_addr <= {r_tgt_y, r_tgt_x};
                        end else begin
                            r_rep_x    <= 6'(r_run_x);
                            r_rep_y    <= 6'(r_run_y);
                            r_rep_addr <= {r_run_y, r_run_x};
                        end
                    end
                    CMD_READ: begin
                        r_rep_x    <= i_req.data.cell_x;
                        r_rep_y    <= i_req.data.cell_y;
                        r_rep_addr <= {RW'(i_req.data.cell_y), CW'(i_req.data.cell_x)};
                        r_rep_in   <= ({3'b000, i_req.data.cell_x} < MAXC) &&
                                      ({3'b000, i_req.data.cell_y} < MAXR);
                    end
                    default: begin
                        r_rep_x    <= 6'(r_run_x);
                        r_rep_y    <= 6'(r_run_y);
                        r_rep_addr <= {r_run_y, r_run_x};
                        r_rep_in   <= 1'b1;
                    end
                endcase
            end
            S_ARR_WR: begin
                r_cell <= cell_wdata;
                r_cand <= '0;
            end
            S_SCAN: begin
                // issue this direction, judge the one read last cycle
                r_prev_ok <= scan_ok;
                if (r_dir != 3'd0) begin
                    r_cand[prev_dir]    <= r_prev_ok && !cell_rdata[BIT_VISITED];
                    r_nb_cell[prev_dir] <= cell_rdata;
                end
            end
            S_PICK: begin
                r_pick_dir <= pick_dir;
            end
            S_REP_OUT: begin
                if (out_free) begin
                    r_out.pos_x        <= r_rep_x;
                    r_out.pos_y        <= r_rep_y;
                    r_out.next_x       <= 6'(r_tgt_x);
                    r_out.next_y       <= 6'(r_tgt_y);
                    r_out.wall_bits    <= r_rep_in ? cell_rdata[3:0] : 4'd0;
                    r_out.visited_mark <= r_rep_in && cell_rdata[BIT_VISITED];
                    r_out.trail_mark   <= r_rep_in && cell_rdata[BIT_TRAIL];
                    r_out.generating   <= r_active;
                    r_out.stack_depth  <= 13'(r_sp);
                end
            end
            default: ;
        endcase
    end

endmodule

// File: tb/mbg_walk_checker.sv
// Response checker for the maze generator: mirrors the walk and compares every response.
`timescale 1ns / 1ps
module mbg_walk_checker import mbg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    mbg_req_if   i_req,
    mbg_rsp_if   i_rsp,
    mbg_cfg_if   i_cfg,
    output int   o_fail_count
);

    localparam int GRID_COLS  = 64;
    localparam int GRID_ROWS  = 64;
    localparam int PATH_DEPTH = 4096;
    localparam int REPORT_MAX = 10;

    // Mirror of the block's grid, path stack and walker
    logic [5:0]  cell_q   [GRID_COLS*GRID_ROWS];
    logic [5:0]  path_col [PATH_DEPTH];
    logic [5:0]  path_row [PATH_DEPTH];
    int unsigned path_len;
    int unsigned run_c, run_r, tgt_c, tgt_r;
    bit          walking;
    logic [6:0]  cols_reg, rows_reg;

    t_rsp        report_q [$];
    int          errors;

    function automatic int unsigned grid_dim(input logic [6:0] v, input int unsigned limit);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > limit) return limit;
        return v;
    endfunction

    function automatic logic [5:0] cell_at(input int unsigned c, input int unsigned r);
        if (c >= GRID_COLS || r >= GRID_ROWS) return '0;
        return cell_q[r * GRID_COLS + c];
    endfunction

    function automatic void cell_mark(input int unsigned c, input int unsigned r,
                                      input logic [5:0] bits);
        if (c < GRID_COLS && r < GRID_ROWS) cell_q[r * GRID_COLS + c] |= bits;
    endfunction

    function automatic void cell_unmark(input int unsigned c, input int unsigned r,
                                        input logic [5:0] bits);
        if (c < GRID_COLS && r < GRID_ROWS) cell_q[r * GRID_COLS + c] &= ~bits;
    endfunction

    function automatic void clear_grid();
        foreach (cell_q[i]) cell_q[i] = CELL_RESET;
    endfunction

    // Neighbour of (c, r) in direction d; false when it falls off the grid in use
    function automatic bit step_to(input int unsigned c, input int unsigned r,
                                   input logic [1:0] d,
                                   output int unsigned nc, output int unsigned nr);
        nc = c;
        nr = r;
        case (d)
            DIR_RIGHT: nc = c + 1;
            DIR_DOWN:  nr = r + 1;
            DIR_LEFT: begin
                if (c == 0) return 1'b0;
                nc = c - 1;
            end
            default: begin
                if (r == 0) return 1'b0;
                nr = r - 1;
            end
        endcase
        return nc < grid_dim(cols_reg, GRID_COLS) && nr < grid_dim(rows_reg, GRID_ROWS);
    endfunction

    // Choose the next target: a random open neighbour, else backtrack, else stop
    function automatic void pick_next(input logic [7:0] rnd);
        logic [1:0]  open_dir [4];
        int unsigned n_open, nc, nr;
        logic [5:0]  nb;
        logic [1:0]  d, back;
        n_open = 0;
        for (int k = 0; k < 4; k++) begin
            d = k[1:0];
            if (step_to(run_c, run_r, d, nc, nr)) begin
                nb = cell_at(nc, nr);
                if (!nb[BIT_VISITED]) begin
                    open_dir[n_open] = d;
                    n_open++;
                end
            end
        end
        if (n_open > 0) begin
            d = open_dir[rnd % n_open];
            void'(step_to(run_c, run_r, d, nc, nr));
            tgt_c = nc;
            tgt_r = nr;
            // knock down the shared wall from both sides; back is the opposite direction
            back = d + 2'd2;
            cell_unmark(run_c, run_r, 6'h01 << d);
            cell_unmark(nc, nr, 6'h01 << back);
        end else if (path_len > 1) begin
            path_len--;
            tgt_c = path_col[path_len - 1];
            tgt_r = path_row[path_len - 1];
        end else begin
            walking = 1'b0;
        end
    endfunction

    // Apply one request to the mirror and return the response it should produce
    function automatic t_rsp predict_walk(input t_req q);
        int unsigned rep_c, rep_r, cx, cy, lim;
        logic [5:0]  here;
        t_rsp        p;
        rep_c = run_c;
        rep_r = run_r;
        case (q.command)
            CMD_RESTART: begin
                cx  = q.cell_x;
                cy  = q.cell_y;
                lim = grid_dim(cols_reg, GRID_COLS);
                if (cx >= lim) cx = lim - 1;
                lim = grid_dim(rows_reg, GRID_ROWS);
                if (cy >= lim) cy = lim - 1;
                clear_grid();
                run_c = cx;
                run_r = cy;
                tgt_c = cx;
                tgt_r = cy;
                path_col[0] = cx[5:0];
                path_row[0] = cy[5:0];
                path_len = 1;
                cell_mark(cx, cy, MARK_VISIT | MARK_TRAIL);
                walking = 1'b1;
                rep_c = cx;
                rep_r = cy;
            end
            CMD_STEP: begin
                if (walking) begin
                    run_c = tgt_c;
                    run_r = tgt_r;
                    here = cell_at(run_c, run_r);
                    if (!here[BIT_VISITED]) begin
                        cell_mark(run_c, run_r, MARK_VISIT | MARK_TRAIL);
                        if (path_len < PATH_DEPTH) begin
                            path_col[path_len] = run_c[5:0];
                            path_row[path_len] = run_r[5:0];
                            path_len++;
                        end
                    end else begin
                        cell_mark(run_c, run_r, MARK_TRAIL);
                    end
                    pick_next(q.random_value);
                end
                rep_c = run_c;
                rep_r = run_r;
            end
            CMD_READ: begin
                rep_c = q.cell_x;
                rep_r = q.cell_y;
            end
            default: ;
        endcase
        here = cell_at(rep_c, rep_r);
        p.pos_x        = rep_c[5:0];
        p.pos_y        = rep_r[5:0];
        p.next_x       = tgt_c[5:0];
        p.next_y       = tgt_r[5:0];
        p.wall_bits    = here[3:0];
        p.visited_mark = here[BIT_VISITED];
        p.trail_mark   = here[BIT_TRAIL];
        p.generating   = walking;
        p.stack_depth  = path_len[12:0];
        return p;
    endfunction

    function automatic string rsp_text(input t_rsp r);
        return $sformatf("pos=(%0d,%0d) next=(%0d,%0d) walls=%h visited=%b trail=%b gen=%b depth=%0d",
                         r.pos_x, r.pos_y, r.next_x, r.next_y, r.wall_bits,
                         r.visited_mark, r.trail_mark, r.generating, r.stack_depth);
    endfunction

    // Compare a response with the oldest pending prediction
    function automatic void check_response(input t_rsp got);
        t_rsp want;
        if (report_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX) $display("unexpected response: %s", rsp_text(got));
            return;
        end
        want = report_q.pop_front();
        if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
            got.next_x !== want.next_x || got.next_y !== want.next_y ||
            got.wall_bits !== want.wall_bits || got.visited_mark !== want.visited_mark ||
            got.trail_mark !== want.trail_mark || got.generating !== want.generating ||
            got.stack_depth !== want.stack_depth) begin
            errors++;
            if (errors <= REPORT_MAX) begin
                $display("response mismatch at %0t", $realtime);
                $display("  expected %s", rsp_text(want));
                $display("  actual   %s", rsp_text(got));
            end
        end
    endfunction

    // Watch all three channels; retire responses before predicting new requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_grid();
            path_len = 0;
            run_c    = 0;
            run_r    = 0;
            tgt_c    = 0;
            tgt_r    = 0;
            walking  = 1'b0;
            cols_reg = CFG_DIM_RESET;
            rows_reg = CFG_DIM_RESET;
            report_q.delete();
            errors   = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) check_response(i_rsp.data);
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.data.index)
                    CFG_COLUMNS: cols_reg = i_cfg.data.value;
                    CFG_ROWS:    rows_reg = i_cfg.data.value;
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) report_q.push_back(predict_walk(i_req.data));
        end
        o_fail_count <= errors + report_q.size();
    end

endmodule

// File: tb/tb.sv
// Top of the maze generator testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module tb import mbg_pkg::*; ();

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam logic [1:0] CFG_UNUSED      = 2'd3;
    localparam int         DIRECTED_ITEMS  = 21;
    localparam int         RANDOM_ITEMS    = 930;
    localparam int         CYCLE_LIMIT     = 1_500_000;
    localparam int         TAIL_CYCLES     = 40;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam int         GRID_MAX        = 64;

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count;
    int unsigned n_sent;
    int unsigned n_recv;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_off_req;
    int unsigned cycle_count;

    mbg_req_if req_ch ();
    mbg_rsp_if rsp_ch ();
    mbg_cfg_if cfg_ch ();

    maze_backtracker_generator_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    mbg_walk_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // End the run if it hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Response side: random back-pressure, plus one long hold-off on demand
    initial begin : rsp_sink
        int unsigned hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) n_recv++;
            if (hold_off_req) begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one request, with random gaps, and hold it until accepted
    task automatic send_req(input logic [1:0] cmd, input logic [5:0] x, input logic [5:0] y,
                            input logic [7:0] rnd);
        t_req r;
        r.command      = cmd;
        r.cell_x       = x;
        r.cell_y       = y;
        r.random_value = rnd;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.data  <= r;
        req_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    // Stop offering and wait for every outstanding response
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (n_recv != n_sent) @(posedge i_clk);
    endtask

    // Write one register; the caller drops valid after the last write
    task automatic write_cfg(input logic [1:0] idx, input logic [6:0] val);
        t_cfg w;
        w.index = idx;
        w.value = val;
        cfg_ch.data  <= w;
        cfg_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    function automatic int unsigned eff_dim(input logic [6:0] v);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > GRID_MAX) return GRID_MAX;
        return v;
    endfunction

    // Mostly small grids, with the extremes and out-of-range values mixed in
    function automatic logic [6:0] pick_dim();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45) return 7'($urandom_range(8, 4));
        if (r < 55) return DIM_MIN;
        if (r < 65) return 7'(GRID_MAX);
        if (r < 75) return 7'($urandom_range(127));
        if (r < 88) return 7'($urandom_range(32, 9));
        return 7'($urandom_range(64, 33));
    endfunction

    // Start a fresh maze, usually inside the grid, sometimes anywhere
    task automatic restart_walk(input int unsigned ce, input int unsigned re);
        if ($urandom_range(99) < 75)
            send_req(CMD_RESTART, 6'($urandom_range(ce - 1)), 6'($urandom_range(re - 1)),
                     8'($urandom_range(255)));
        else
            send_req(CMD_RESTART, 6'($urandom_range(63)), 6'($urandom_range(63)),
                     8'($urandom_range(255)));
    endtask

    initial begin
        logic [6:0]  cols_val, rows_val;
        int unsigned ce, re, len, phase_no, pick;

        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        send_idle_pct = 22;
        recv_idle_pct = 88;
        cols_val      = CFG_DIM_RESET;
        rows_val      = CFG_DIM_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Before any restart: a step finds the walk stopped, reads see the reset grid
        send_req(CMD_STEP, 6'd0, 6'd0, 8'd0);
        send_req(CMD_READ, 6'd0, 6'd0, 8'd0);
        send_req(CMD_READ, 6'd63, 6'd63, 8'd255);
        send_req(CMD_UNUSED, 6'd63, 6'd63, 8'd255);
        // Start outside the default grid: both coordinates clip to the far corner
        send_req(CMD_RESTART, 6'd63, 6'd63, 8'd0);
        send_req(CMD_STEP, 6'd0, 6'd0, 8'd0);
        send_req(CMD_STEP, 6'd63, 6'd63, 8'd255);
        send_req(CMD_STEP, 6'd21, 6'd42, 8'd1);
        send_req(CMD_READ, 6'd31, 6'd31, 8'd0);
        send_req(CMD_UNUSED, 6'd0, 6'd0, 8'd0);

        // Columns below the minimum, rows above the maximum
        drain();
        cols_val = 7'd0;
        rows_val = 7'd127;
        write_cfg(CFG_COLUMNS, cols_val);
        write_cfg(CFG_ROWS, rows_val);
        cfg_ch.valid <= 1'b0;
        send_req(CMD_RESTART, 6'd0, 6'd0, 8'd128);
        send_req(CMD_STEP, 6'd0, 6'd0, 8'd0);
        send_req(CMD_STEP, 6'd0, 6'd0, 8'd255);
        send_req(CMD_STEP, 6'd0, 6'd0, 8'd2);
        send_req(CMD_STEP, 6'd0, 6'd0, 8'd3);

        // Widen the columns and shrink the rows under a running walk, then restart below the last row
        drain();
        cols_val = 7'd127;
        rows_val = 7'd2;
        write_cfg(CFG_COLUMNS, cols_val);
        write_cfg(CFG_ROWS, rows_val);
        cfg_ch.valid <= 1'b0;
        send_req(CMD_STEP, 6'd0, 6'd0, 8'd255);
        send_req(CMD_READ, 6'd3, 6'd3, 8'd0);
        send_req(CMD_RESTART, 6'd0, 6'd63, 8'd0);
        send_req(CMD_STEP, 6'd0, 6'd0, 8'd7);
        send_req(CMD_STEP, 6'd0, 6'd0, 8'd254);
        send_req(CMD_STEP, 6'd0, 6'd0, 8'd5);

        // Random phases: resize while idle, usually restart, then walk
        phase_no = 0;
        while (n_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            if (n_sent < DIRECTED_ITEMS + RANDOM_ITEMS / 3) begin
                send_idle_pct = 22;
                recv_idle_pct = 88;
            end else if (n_sent < DIRECTED_ITEMS + 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 88;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            drain();
            if (phase_no == 0 || $urandom_range(99) < 75) begin
                cols_val = pick_dim();
                write_cfg(CFG_COLUMNS, cols_val);
            end
            if (phase_no == 0 || $urandom_range(99) < 75) begin
                rows_val = pick_dim();
                write_cfg(CFG_ROWS, rows_val);
            end
            if (phase_no == 5) write_cfg(CFG_UNUSED, 7'($urandom_range(127)));
            cfg_ch.valid <= 1'b0;
            ce = eff_dim(cols_val);
            re = eff_dim(rows_val);

            // Skipping the restart keeps walking on the resized grid
            if (phase_no == 0 || $urandom_range(99) < 80) restart_walk(ce, re);

            // Stall the response side long enough to back up the request side
            if (phase_no == 2) hold_off_req = 1'b1;

            // Long enough for small mazes to finish and take a few idle steps
            len = $urandom_range(80, 30);
            if (3 * ce * re + 6 < len) len = 3 * ce * re + 6;
            for (int unsigned k = 0; k < len && n_sent < DIRECTED_ITEMS + RANDOM_ITEMS;
                 k++) begin
                // Pause the sender until every response is back
                if (phase_no == 4 && k == len / 2) drain();
                pick = $urandom_range(99);
                if (pick < 85) begin
                    send_req(CMD_STEP, 6'($urandom_range(63)), 6'($urandom_range(63)),
                             8'($urandom_range(255)));
                end else if (pick < 94) begin
                    if ($urandom_range(99) < 70)
                        send_req(CMD_READ, 6'($urandom_range(ce - 1)),
                                 6'($urandom_range(re - 1)), 8'($urandom_range(255)));
                    else
                        send_req(CMD_READ, 6'($urandom_range(63)), 6'($urandom_range(63)),
                                 8'($urandom_range(255)));
                end else if (pick < 99) begin
                    send_req(CMD_UNUSED, 6'($urandom_range(63)), 6'($urandom_range(63)),
                             8'($urandom_range(255)));
                end else begin
                    restart_walk(ce, re);
                end
            end
            phase_no++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
